// ===== rtl/evep_pkg.sv =====
// Package for the energy VAD endpointer: sizes, codes and item types.
// Used by every module of the block; depends on nothing.
package evep_pkg;

    localparam int FRAME_MAX  = 4096;
    localparam int CNT_W      = $clog2(FRAME_MAX + 1);       // frame length n
    localparam int SQ_W       = 31;                          // one squared sample
    localparam int SUM_W      = SQ_W + $clog2(FRAME_MAX);    // frame energy
    localparam int THR_W      = 15;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int LIM_W      = THR_SQ_W + CNT_W;
    localparam int CMP_W      = (SUM_W > LIM_W) ? SUM_W : LIM_W;
    localparam int RUN_W      = 8;
    localparam int LIMIT_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HANG_LIMIT  = 3'd4;

    // reset values
    localparam logic [THR_W-1:0]   RST_SPEECH_THR = 15'd655;
    localparam logic [THR_W-1:0]   RST_QUIET_THR  = 15'd328;
    localparam logic [RUN_W-1:0]   RST_START_FRM  = 8'd2;
    localparam logic [LIMIT_W-1:0] RST_END_LIMIT  = 24'd12800;
    localparam logic [LIMIT_W-1:0] RST_HANG_LIMIT = 24'd4800;
    localparam logic [RUN_W-1:0]   DEFAULT_NEED   = 8'd2;

    typedef enum logic [1:0] {
        MODE_SILENCE  = 2'd0,
        MODE_SPEECH   = 2'd1,
        MODE_HANGOVER = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } t_event;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               frame_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] vad_state;
        logic       frame_is_speech;
    } t_out_item;

    // one finished frame, front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] n;
    } t_frame;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/evep_fifo.sv =====
// Short frame queue between the sample front end and the decision back end.
// Depends on evep_pkg.
module evep_fifo
    import evep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_frame    i_wr_data,
    input  logic      i_pop,
    output t_frame    o_rd_data,
    output t_q_status o_status
);

    t_frame                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_data       = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("frame queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("frame queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
        else $error("frame queue count out of range");
`endif

endmodule

// ===== rtl/evep_front.sv =====
// Sample front end: squares samples, accumulates frame energy and length,
// and queues each finished frame. Depends on evep_pkg.
module evep_front
    import evep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_frame    o_frame
);

    logic             r_s1_valid;
    logic             r_s1_end;
    logic [SQ_W-1:0]  r_s1_sq;
    logic [CNT_W-1:0] r_s1_n;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_acc;

    logic             s1_adv;
    logic             accept;
    logic [CNT_W-1:0] n_in;
    logic             end_in;
    logic [31:0]      sq_full;
    logic [SUM_W-1:0] acc_sum;

    // stage 1 holds only when it carries a frame end and the queue is full
    assign s1_adv     = !(r_s1_valid && r_s1_end && i_q_status.full);
    assign o_in_stall = !s1_adv;
    assign accept     = i_in_valid && s1_adv;

    assign n_in    = r_count + 1'b1;
    assign end_in  = i_in_item.frame_last || (n_in >= CNT_W'(FRAME_MAX));
    assign sq_full = 32'($signed(i_in_item.sample) * $signed(i_in_item.sample));
    assign acc_sum = r_acc + SUM_W'(r_s1_sq);

    assign o_push      = r_s1_valid && r_s1_end && s1_adv;
    assign o_frame.sum = acc_sum;
    assign o_frame.n   = r_s1_n;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sq  <= sq_full[SQ_W-1:0];
            r_s1_end <= end_in;
            r_s1_n   <= n_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_count    <= '0;
            r_acc      <= '0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= accept;
            end
            if (accept) begin
                r_count <= end_in ? '0 : n_in;
            end
            if (r_s1_valid && s1_adv) begin
                r_acc <= r_s1_end ? '0 : acc_sum;
            end
        end
    end

endmodule

// ===== rtl/evep_back.sv =====
// Decision back end: configuration registers, threshold limits, the
// silence/speech/hangover machine and the result register. Depends on evep_pkg.
module evep_back
    import evep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_status             i_q_status,
    input  t_frame                i_frame,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_MUL    = 2'd1,
        ST_DECIDE = 2'd2
    } t_state;

    t_state               r_state;
    logic [THR_W-1:0]     r_speech_thr;
    logic [THR_W-1:0]     r_quiet_thr;
    logic [RUN_W-1:0]     r_start_frm;
    logic [LIMIT_W-1:0]   r_end_limit;
    logic [LIMIT_W-1:0]   r_hang_limit;
    logic [THR_SQ_W-1:0]  r_sq_s;
    logic [THR_SQ_W-1:0]  r_sq_q;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_n;
    logic [LIM_W-1:0]     r_lim_s;
    logic [LIM_W-1:0]     r_lim_q;
    t_mode                r_mode;
    logic [RUN_W-1:0]     r_run;
    logic [LIMIT_W-1:0]   r_quiet;
    logic [LIMIT_W-1:0]   r_hang;

    t_mode                n_mode;
    logic [RUN_W-1:0]     n_run;
    logic [LIMIT_W-1:0]   n_quiet;
    logic [LIMIT_W-1:0]   n_hang;
    t_event               n_event;

    logic                 speech;
    logic                 quiet;
    logic [LIMIT_W:0]     quiet_add;
    logic [LIMIT_W:0]     hang_add;
    logic [LIMIT_W-1:0]   quiet_sat;
    logic [LIMIT_W-1:0]   hang_sat;
    logic [RUN_W-1:0]     run_inc;
    logic [RUN_W-1:0]     need;
    logic                 out_free;

    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;
    assign out_free = !o_out_valid || !i_out_stall;

    assign speech = CMP_W'(r_sum) > CMP_W'(r_lim_s);
    assign quiet  = CMP_W'(r_sum) < CMP_W'(r_lim_q);

    assign quiet_add = {1'b0, r_quiet} + (LIMIT_W + 1)'(r_n);
    assign hang_add  = {1'b0, r_hang} + (LIMIT_W + 1)'(r_n);
    assign quiet_sat = quiet_add[LIMIT_W] ? '1 : quiet_add[LIMIT_W-1:0];
    assign hang_sat  = hang_add[LIMIT_W] ? '1 : hang_add[LIMIT_W-1:0];
    assign run_inc   = (r_run == '1) ? r_run : r_run + 1'b1;
    assign need      = (r_start_frm == '0) ? DEFAULT_NEED : r_start_frm;

    always_comb begin
        n_mode  = r_mode;
        n_run   = r_run;
        n_quiet = r_quiet;
        n_hang  = r_hang;
        n_event = EV_NONE;
        unique case (r_mode)
            MODE_SPEECH: begin
                if (quiet) begin
                    n_quiet = quiet_sat;
                    if (quiet_sat >= r_end_limit) begin
                        n_mode  = MODE_HANGOVER;
                        n_hang  = '0;
                        n_event = EV_END;
                    end
                end else begin
                    n_quiet = '0;
                end
            end
            MODE_HANGOVER: begin
                n_hang = hang_sat;
                if (speech) begin
                    n_mode  = MODE_SPEECH;
                    n_quiet = '0;
                    n_hang  = '0;
                end else if (hang_sat >= r_hang_limit) begin
                    n_mode  = MODE_SILENCE;
                    n_quiet = '0;
                end
            end
            default: begin
                // silence, and the unused code taken as silence
                n_mode = MODE_SILENCE;
                if (speech) begin
                    n_run = run_inc;
                    if (run_inc >= need) begin
                        n_mode  = MODE_SPEECH;
                        n_quiet = '0;
                        n_run   = '0;
                        n_event = EV_START;
                    end
                end else begin
                    n_run = '0;
                end
            end
        endcase
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_sq_s <= THR_SQ_W'(r_speech_thr * r_speech_thr);
        r_sq_q <= THR_SQ_W'(r_quiet_thr * r_quiet_thr);
        if (o_pop) begin
            r_sum <= i_frame.sum;
            r_n   <= i_frame.n;
        end
        if (r_state == ST_MUL) begin
            r_lim_s <= LIM_W'(r_sq_s * r_n);
            r_lim_q <= LIM_W'(r_sq_q * r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speech_thr <= RST_SPEECH_THR;
            r_quiet_thr  <= RST_QUIET_THR;
            r_start_frm  <= RST_START_FRM;
            r_end_limit  <= RST_END_LIMIT;
            r_hang_limit <= RST_HANG_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEECH_THR: r_speech_thr <= i_cfg_data[THR_W-1:0];
                CFG_QUIET_THR:  r_quiet_thr  <= i_cfg_data[THR_W-1:0];
                CFG_START_FRM:  r_start_frm  <= i_cfg_data[RUN_W-1:0];
                CFG_END_LIMIT:  r_end_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_HANG_LIMIT: r_hang_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, VAD state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_SILENCE;
            r_run       <= '0;
            r_quiet     <= '0;
            r_hang      <= '0;
            o_out_valid <= 1'b0;
            o_out_item  <= '0;
        end else begin
            // in decide a taken result is replaced by the next one
            if (o_out_valid && !i_out_stall && r_state != ST_DECIDE) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        r_mode      <= n_mode;
                        r_run       <= n_run;
                        r_quiet     <= n_quiet;
                        r_hang      <= n_hang;
                        o_out_valid <= 1'b1;
                        o_out_item.event_res       <= n_event;
                        o_out_item.vad_state       <= n_mode;
                        o_out_item.frame_is_speech <= speech;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_start_means_speech: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_res == EV_START) |->
            (o_out_item.vad_state == MODE_SPEECH && o_out_item.frame_is_speech))
        else $error("speech start without speech state");
    a_end_means_hangover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.event_res == EV_END) |->
            (o_out_item.vad_state == MODE_HANGOVER))
        else $error("speech end without hangover state");
    a_result_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.vad_state == r_mode))
        else $error("reported state differs from held mode");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_pop)
        else $error("frame taken while busy");
`endif

endmodule

// ===== rtl/energy_vad_endpointer_core.sv =====
// Energy VAD endpointer, top level. A frame's result follows its last accepted
// sample through the sample stage, queue write, queue read, limit multiply
// and decide. Throughput: one sample per cycle; the front stalls only when four
// finished frames wait in the queue, as the back takes frames one by one.
// Reset (i_rst_n low, synchronous) clears counters, mode, queue and the result
// register, and returns all configuration registers to their reset values.
module energy_vad_endpointer_core
    import evep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_q_status q_status;
    t_frame    push_frame;
    t_frame    head_frame;
    logic      push;
    logic      pop;

    // registers are plain flops, a write always lands
    assign o_cfg_ready = 1'b1;

    // front: square and accumulate at sample rate, hand off whole frames
    evep_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_frame    (push_frame)
    );

    // queue of finished frames (energy sum and length)
    evep_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_frame),
        .i_pop     (pop),
        .o_rd_data (head_frame),
        .o_status  (q_status)
    );

    // back: exact RMS tests as sum vs thr^2*n, then the three-state machine
    evep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .i_frame     (head_frame),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== bench/evep_checker.sv =====
// Checker for the energy VAD endpointer: watches the sample, result and
// configuration channels, predicts each frame decision and compares it.
// Depends on evep_pkg for the item types, codes and reset values.
module evep_checker
    import evep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // configuration copy
    logic [THR_W-1:0]   speech_thr;
    logic [THR_W-1:0]   quiet_thr;
    logic [RUN_W-1:0]   start_need;
    logic [LIMIT_W-1:0] end_limit;
    logic [LIMIT_W-1:0] hang_limit;

    // detector state
    logic [SUM_W-1:0]   frame_energy;
    logic [CNT_W-1:0]   frame_len;
    t_mode              vad_mode;
    logic [RUN_W-1:0]   speech_run;
    logic [LIMIT_W-1:0] quiet_run;
    logic [LIMIT_W-1:0] hang_run;

    t_out_item          decisions_due[$];
    int                 fail_count = 0;
    int                 results_seen = 0;

    // threshold squared times frame length, exact
    function automatic longint unsigned level_sq_n(input logic [THR_W-1:0] thr,
                                                   input longint unsigned n);
        longint unsigned t;
        t = thr;
        return t * t * n;
    endfunction

    function automatic logic [LIMIT_W-1:0] add_sat(input logic [LIMIT_W-1:0] a,
                                                   input longint unsigned n);
        longint unsigned s;
        s = a + n;
        return (s > longint'({LIMIT_W{1'b1}})) ? {LIMIT_W{1'b1}} : LIMIT_W'(s);
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // accumulate one sample; at frame end run the mode machine
    task automatic track_sample(input t_in_item it);
        int               smp;
        longint unsigned  mag;
        longint unsigned  energy;
        longint unsigned  n;
        logic             frm_loud;
        logic [RUN_W-1:0] need;
        t_event           ev;
        t_out_item        res;
        smp = $signed(it.sample);
        mag = (smp < 0) ? -smp : smp;
        energy = frame_energy + mag * mag;
        n = frame_len + 1;
        if (!it.frame_last && n < FRAME_MAX) begin
            frame_energy = SUM_W'(energy);
            frame_len    = CNT_W'(n);
        end else begin
            frame_energy = '0;
            frame_len    = '0;
            frm_loud     = energy > level_sq_n(speech_thr, n);
            ev           = EV_NONE;
            case (vad_mode)
                MODE_SPEECH: begin
                    // strictly below the quiet level; a tie is not quiet
                    if (energy < level_sq_n(quiet_thr, n)) begin
                        quiet_run = add_sat(quiet_run, n);
                        if (quiet_run >= end_limit) begin
                            vad_mode = MODE_HANGOVER;
                            hang_run = '0;
                            ev       = EV_END;
                        end
                    end else begin
                        quiet_run = '0;
                    end
                end
                MODE_HANGOVER: begin
                    hang_run = add_sat(hang_run, n);
                    if (frm_loud) begin
                        vad_mode  = MODE_SPEECH;
                        quiet_run = '0;
                        hang_run  = '0;
                    end else if (hang_run >= hang_limit) begin
                        vad_mode  = MODE_SILENCE;
                        quiet_run = '0;
                    end
                end
                default: begin
                    vad_mode = MODE_SILENCE;
                    need = (start_need == '0) ? DEFAULT_NEED : start_need;
                    if (frm_loud) begin
                        if (speech_run != {RUN_W{1'b1}})
                            speech_run = speech_run + 1'b1;
                        if (speech_run >= need) begin
                            vad_mode   = MODE_SPEECH;
                            quiet_run  = '0;
                            speech_run = '0;
                            ev         = EV_START;
                        end
                    end else begin
                        speech_run = '0;
                    end
                end
            endcase
            res.event_res       = ev;
            res.vad_state       = vad_mode;
            res.frame_is_speech = frm_loud;
            decisions_due.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp;
        if (!i_rst_n) begin
            speech_thr   = RST_SPEECH_THR;
            quiet_thr    = RST_QUIET_THR;
            start_need   = RST_START_FRM;
            end_limit    = RST_END_LIMIT;
            hang_limit   = RST_HANG_LIMIT;
            frame_energy = '0;
            frame_len    = '0;
            vad_mode     = MODE_SILENCE;
            speech_run   = '0;
            quiet_run    = '0;
            hang_run     = '0;
            decisions_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPEECH_THR: speech_thr = i_cfg_data[THR_W-1:0];
                    CFG_QUIET_THR:  quiet_thr  = i_cfg_data[THR_W-1:0];
                    CFG_START_FRM:  start_need = i_cfg_data[RUN_W-1:0];
                    CFG_END_LIMIT:  end_limit  = i_cfg_data[LIMIT_W-1:0];
                    CFG_HANG_LIMIT: hang_limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                track_sample(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (decisions_due.size() == 0) begin
                    flag_error($sformatf({"evep_checker: result %0d unexpected: ",
                        "event %0d state %0d speech %0d"},
                        results_seen, i_out_item.event_res, i_out_item.vad_state,
                        i_out_item.frame_is_speech));
                end else begin
                    exp = decisions_due.pop_front();
                    if (i_out_item.event_res !== exp.event_res ||
                        i_out_item.vad_state !== exp.vad_state ||
                        i_out_item.frame_is_speech !== exp.frame_is_speech)
                        flag_error($sformatf({"evep_checker: result %0d mismatch: ",
                            "expected event %0d state %0d speech %0d, ",
                            "got event %0d state %0d speech %0d"},
                            results_seen, exp.event_res, exp.vad_state, exp.frame_is_speech,
                            i_out_item.event_res, i_out_item.vad_state,
                            i_out_item.frame_is_speech));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= decisions_due.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the energy VAD endpointer bench: clock, reset, sample and register
// stimulus, receiver stalls, watchdog and verdict.
// Depends on evep_pkg, energy_vad_endpointer_core and evep_checker.
module tb_top;
    import evep_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 12;    // margin on top of the result latency
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 135;
    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_HANG_LIMIT + 3'd1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int stuck_cycles  = 0;

    // thresholds as last written, used only to aim the sample levels
    logic [THR_W-1:0] cur_speech_thr = RST_SPEECH_THR;
    logic [THR_W-1:0] cur_quiet_thr  = RST_QUIET_THR;

    energy_vad_endpointer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    evep_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side back-pressure, redrawn every cycle.
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Watchdog: any handshake on any channel clears it.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // One sample item. Idle cycles go in front at the sender's rate; once
    // valid is up it stays up with a fixed payload until accepted.
    task automatic push_sample(input int smp, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= {16'(smp), last};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // A frame of len samples with magnitude level +- spread, random signs.
    // Magnitude 32768 exists only as the negative full-scale sample.
    task automatic push_frame(input int len, input int level, input int spread);
        int mag;
        int smp;
        for (int k = 0; k < len; k++) begin
            mag = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (mag < 0)
                mag = 0;
            if (mag > 32768)
                mag = 32768;
            if (mag == 32768)
                smp = -32768;
            else
                smp = $urandom_range(0, 1) ? -mag : mag;
            push_sample(smp, k == len - 1);
        end
    endtask

    // Mostly well-formed frames aimed around the two thresholds, so the mode
    // machine walks through start, end and hangover; some raw noise with
    // frame marks at random.
    task automatic push_random_frame(output int sent);
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
        sent = len;
        if (pick < 10) begin
            for (int k = 0; k < len; k++)
                push_sample(int'($urandom_range(0, 65535)), $urandom_range(0, 5) == 0);
        end else if (pick < 42) begin
            push_frame(len, cur_speech_thr + int'($urandom_range(1, 300)), 3);  // loud
        end else if (pick < 52) begin
            push_frame(len, cur_speech_thr, 0);       // energy exactly at speech level
        end else if (pick < 58) begin
            push_frame(len, cur_quiet_thr, 0);        // energy exactly at quiet level
        end else if (pick < 74) begin
            push_frame(len, int'($urandom_range(cur_quiet_thr, cur_speech_thr)), 2);
        end else if (pick < 92) begin
            push_frame(len, int'($urandom_range(0, cur_quiet_thr)), 2);  // quiet
        end else begin
            push_frame(len, 0, 0);                    // digital silence
        end
    endtask

    // Wait until every frame decision is back, then let the pipe empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SPEECH_THR: cur_speech_thr = val[THR_W-1:0];
            CFG_QUIET_THR:  cur_quiet_thr  = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set; junk in the unused upper data bits, plus one write
    // to an index that does not exist.
    task automatic configure(input logic [THR_W-1:0] sp, input logic [THR_W-1:0] qt,
                             input logic [RUN_W-1:0] st, input logic [LIMIT_W-1:0] el,
                             input logic [LIMIT_W-1:0] hl);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(CFG_SPEECH_THR, {junk[8:0], sp});
        write_reg(CFG_QUIET_THR, {junk[17:9], qt});
        write_reg(CFG_START_FRM, {junk[15:0], st});
        write_reg(CFG_END_LIMIT, el);
        write_reg(CFG_HANG_LIMIT, hl);
        write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), junk);
    endtask

    initial begin
        int done;
        int sent;
        logic [THR_W-1:0] sp;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset values: one-sample frames straddling the
        // default levels, ties on both levels, full-scale samples.
        push_sample(656, 1'b1);      // just above speech level, run of one
        push_sample(-656, 1'b1);     // second speech frame: speech start
        push_sample(328, 1'b1);      // tie on quiet level is not quiet
        push_sample(-327, 1'b1);     // quiet, counts one sample
        push_sample(655, 1'b0);      // two-sample tie on speech level
        push_sample(-655, 1'b1);
        push_sample(32767, 1'b1);
        push_sample(-32768, 1'b1);
        push_sample(0, 1'b1);
        drain();

        // Zero limits and a start count of one: every transition fires on
        // the first frame that qualifies.
        write_reg(CFG_START_FRM, 24'd1);
        write_reg(CFG_END_LIMIT, 24'd0);
        write_reg(CFG_HANG_LIMIT, 24'd0);
        push_sample(0, 1'b1);        // speech -> hangover, speech end
        push_sample(1000, 1'b1);     // hangover -> speech, no event
        push_sample(0, 1'b1);        // speech end again
        push_sample(0, 1'b1);        // hangover -> silence
        push_sample(-1000, 1'b1);    // speech start on one frame

        // Forced frame end: a full-scale frame that never sets frame_last,
        // giving the largest frame energy, then a short frame after it.
        for (int k = 0; k < FRAME_MAX; k++)
            push_sample(-32768, 1'b0);
        push_sample(5, 1'b1);
        drain();

        // Random phases. The first three hold the register extremes, the rest
        // draw small limits so that endpoints happen often.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure('0, '0, '0, {LIMIT_W{1'b1}}, {LIMIT_W{1'b1}});
                1: configure({THR_W{1'b1}}, {THR_W{1'b1}}, {RUN_W{1'b1}}, '0, '0);
                2: configure({THR_W{1'b1}}, {THR_W{1'b1}}, 8'd1, '0, '0);
                default: begin
                    sp = $urandom_range(200, 6000);
                    configure(sp, $urandom_range(0, sp), $urandom_range(0, 4),
                              $urandom_range(0, 120), $urandom_range(0, 120));
                end
            endcase

            case (t_idle'(p % 4))
                IDLE_SENDER: begin
                    send_idle_pct = 74;
                    stall_pct    <= 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    stall_pct    <= 74;
                end
                IDLE_BOTH: begin
                    send_idle_pct = 14;
                    stall_pct    <= 14;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
            endcase

            done = 0;
            while (done < PHASE_ITEMS) begin
                push_random_frame(sent);
                done += sent;
            end
            push_sample(int'($urandom_range(0, 65535)), 1'b1);  // close the last frame
            drain();
        end

        if (fail_count == 0 && pending_results == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
